@@ rtl/velocity_vector_from_segment_macros.svh @@
`ifndef VELOCITY_VECTOR_FROM_SEGMENT_MACROS_SVH
`define VELOCITY_VECTOR_FROM_SEGMENT_MACROS_SVH

// same-cycle implication, reset masked
`define VVFS_ASSERT_NOW(lbl, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (c)) \
		else $error("check failed");

// next-cycle implication, reset masked
`define VVFS_ASSERT_NEXT(lbl, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (c)) \
		else $error("check failed");

`endif

@@ rtl/vvfs_pkg.sv @@
`timescale 1ns / 1ps
package vvfs_pkg;
	localparam int FRAC_BITS = 16;
	localparam int DW = 33;
	localparam int SW = 67;
	localparam int RAD_W = SW + 2 * FRAC_BITS;
	localparam int RW = (RAD_W + 1) / 2;
	localparam int NW = 64 + FRAC_BITS;
	localparam int QW = 32;

	typedef struct packed {
		logic [2:0][NW-1:0] num;
		logic [2:0]         neg;
		logic               degen;
	} sq_pl_t;

	typedef struct packed {
		logic [RW-1:0]         r;
		logic [2:0][RW-1:0]    rem;
		logic [2:0][QW-1:0]    nlow;
		logic [2:0][QW-1:0]    q;
		logic [2:0]            neg;
		logic                  degen;
	} dv_t;
endpackage

@@ rtl/vvfs_sqrt_cell.sv @@
`timescale 1ns / 1ps
module vvfs_sqrt_cell (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           en,
	input  logic                           vld_i,
	input  logic [2*vvfs_pkg::RW-1:0]      rad_i,
	input  logic [vvfs_pkg::RW:0]          rem_i,
	input  logic [vvfs_pkg::RW-1:0]        root_i,
	input  vvfs_pkg::sq_pl_t               pl_i,
	output logic                           vld_o,
	output logic [2*vvfs_pkg::RW-1:0]      rad_o,
	output logic [vvfs_pkg::RW:0]          rem_o,
	output logic [vvfs_pkg::RW-1:0]        root_o,
	output vvfs_pkg::sq_pl_t               pl_o
);
	import vvfs_pkg::*;

	logic [RW+2:0] t;
	logic [RW+2:0] trial;
	logic [RW+2:0] nrem;
	logic          ge;

	always_comb begin
		t = {rem_i, rad_i[2*RW-1 -: 2]};
		trial = {1'b0, root_i, 2'b01};
		ge = (t >= trial);
		nrem = ge ? (t - trial) : t;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_o <= 1'b0;
		end else if (en) begin
			vld_o <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rad_o <= {rad_i[2*RW-3:0], 2'b00};
			rem_o <= nrem[RW:0];
			root_o <= {root_i[RW-2:0], ge};
			pl_o <= pl_i;
		end
	end
endmodule

@@ rtl/vvfs_div_cell.sv @@
`timescale 1ns / 1ps
module vvfs_div_cell (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          vld_i,
	input  vvfs_pkg::dv_t dv_i,
	output logic          vld_o,
	output vvfs_pkg::dv_t dv_o
);
	import vvfs_pkg::*;

	logic [2:0][RW:0] t;
	logic [2:0][RW:0] nrem;
	logic [2:0]       ge;
	dv_t              nxt;

	always_comb begin
		nxt = dv_i;
		for (int i = 0; i < 3; i++) begin
			t[i] = {dv_i.rem[i], dv_i.nlow[i][QW-1]};
			ge[i] = (t[i] >= {1'b0, dv_i.r});
			nrem[i] = ge[i] ? (t[i] - {1'b0, dv_i.r}) : t[i];
			nxt.rem[i] = nrem[i][RW-1:0];
			nxt.nlow[i] = {dv_i.nlow[i][QW-2:0], 1'b0};
			nxt.q[i] = {dv_i.q[i][QW-2:0], ge[i]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_o <= 1'b0;
		end else if (en) begin
			vld_o <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dv_o <= nxt;
		end
	end
endmodule

@@ rtl/velocity_vector_from_segment.sv @@
`timescale 1ns / 1ps
// Velocity of one motion segment: speed * (target - origin) / |target - origin|.
// Input channel: in_valid/in_stall with target_x/y/z, origin_x/y/z, speed
// (signed fixed point, FRAC_BITS fraction bits). An item is taken when
// in_valid is high and in_stall is low.
// Output channel: out_valid/out_stall with vel_x/y/z, degenerate, clipped.
// One result per item, in order.
// Throughput: one item per cycle while no result is held at the output under out_stall.
// Stages: difference, multiply and sum registers, then the square root cell
// row with one cell per root bit (RW = 50), the divider cell row with one
// cell per quotient bit, and the output register.
// Reset clears all valid bits; the pipeline starts empty.
// While a result is held at the output under out_stall, the whole pipeline
// freezes and in_stall is high; nothing is lost or repeated.
// Equal points give zero velocity with degenerate set.
`include "velocity_vector_from_segment_macros.svh"
module velocity_vector_from_segment (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] target_x,
	input  logic [31:0] target_y,
	input  logic [31:0] target_z,
	input  logic [31:0] origin_x,
	input  logic [31:0] origin_y,
	input  logic [31:0] origin_z,
	input  logic [31:0] speed,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] vel_x,
	output logic [31:0] vel_y,
	output logic [31:0] vel_z,
	output logic        degenerate,
	output logic        clipped
);
	import vvfs_pkg::*;

	logic adv;
	assign adv = !(out_valid && out_stall);
	assign in_stall = !adv;

	logic [2:0][31:0] tgt;
	logic [2:0][31:0] org;
	assign tgt = {target_z, target_y, target_x};
	assign org = {origin_z, origin_y, origin_x};

	logic [2:0][DW-1:0] dif;
	logic               vld_s1;
	logic [2:0][DW-1:0] dm_s1;
	logic [2:0]         neg_s1;
	logic [31:0]        sm_s1;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			dif[i] = {tgt[i][31], tgt[i]} - {org[i][31], org[i]};
		end
	end

	logic vld_s2;
	logic [2:0][2*DW-1:0] sq_s2;
	logic [2:0][63:0]     pr_s2;
	logic [2:0]           neg_s2;

	logic vld_s3;
	logic [SW-1:0]        sum_s3;
	sq_pl_t               pl_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	logic [2*DW+1:0] sum_w;
	assign sum_w = {2'b00, sq_s2[0]} + {2'b00, sq_s2[1]} + {2'b00, sq_s2[2]};

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				dm_s1[i] <= dif[i][DW-1] ? (DW'(0) - dif[i]) : dif[i];
				neg_s1[i] <= speed[31] ^ dif[i][DW-1];
				sq_s2[i] <= (2*DW)'(dm_s1[i] * dm_s1[i]);
				pr_s2[i] <= 64'({31'd0, dm_s1[i]} * {32'd0, sm_s1});
				pl_s3.num[i] <= {pr_s2[i], {FRAC_BITS{1'b0}}};
			end
			sm_s1 <= speed[31] ? (32'd0 - speed) : speed;
			neg_s2 <= neg_s1;
			sum_s3 <= SW'(sum_w);
			pl_s3.neg <= neg_s2;
			pl_s3.degen <= (sum_w == '0);
		end
	end

	logic                sv   [0:RW];
	logic [2*RW-1:0]     srad [0:RW];
	logic [RW:0]         srem [0:RW];
	logic [RW-1:0]       sroot[0:RW];
	sq_pl_t              spl  [0:RW];

	assign sv[0] = vld_s3;
	assign srad[0] = (2*RW)'(sum_s3) << (2 * FRAC_BITS);
	assign srem[0] = '0;
	assign sroot[0] = '0;
	assign spl[0] = pl_s3;

	for (genvar g = 0; g < RW; g++) begin : g_sqrt
		vvfs_sqrt_cell u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.en    (adv),
			.vld_i (sv[g]),
			.rad_i (srad[g]),
			.rem_i (srem[g]),
			.root_i(sroot[g]),
			.pl_i  (spl[g]),
			.vld_o (sv[g+1]),
			.rad_o (srad[g+1]),
			.rem_o (srem[g+1]),
			.root_o(sroot[g+1]),
			.pl_o  (spl[g+1])
		);
	end

	logic dvv [0:QW];
	dv_t  dvd [0:QW];

	always_comb begin
		dvd[0].r = sroot[RW];
		for (int i = 0; i < 3; i++) begin
			dvd[0].rem[i] = RW'(spl[RW].num[i] >> QW);
			dvd[0].nlow[i] = spl[RW].num[i][QW-1:0];
			dvd[0].q[i] = '0;
		end
		dvd[0].neg = spl[RW].neg;
		dvd[0].degen = spl[RW].degen;
	end
	assign dvv[0] = sv[RW];

	for (genvar g = 0; g < QW; g++) begin : g_div
		vvfs_div_cell u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.en    (adv),
			.vld_i (dvv[g]),
			.dv_i  (dvd[g]),
			.vld_o (dvv[g+1]),
			.dv_o  (dvd[g+1])
		);
	end

	logic [2:0][31:0] vel;
	logic [2:0]       sat;
	dv_t              fin;

	always_comb begin
		fin = dvd[QW];
		for (int i = 0; i < 3; i++) begin
			sat[i] = !fin.neg[i] && fin.q[i][31];
			if (fin.degen) begin
				vel[i] = '0;
			end else if (sat[i]) begin
				vel[i] = 32'h7FFF_FFFF;
			end else if (fin.neg[i]) begin
				vel[i] = 32'd0 - fin.q[i];
			end else begin
				vel[i] = fin.q[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= dvv[QW];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			vel_x <= vel[0];
			vel_y <= vel[1];
			vel_z <= vel[2];
			degenerate <= fin.degen;
			clipped <= !fin.degen && (sat != 3'b000);
		end
	end

	`VVFS_ASSERT_NOW(a_degen_zero, out_valid && degenerate, vel_x == 32'd0 && vel_y == 32'd0 && vel_z == 32'd0 && !clipped)
	`VVFS_ASSERT_NOW(a_stall_src, in_stall, out_valid && out_stall)
	`VVFS_ASSERT_NEXT(a_take_s1, in_valid && !in_stall, vld_s1)
	`VVFS_ASSERT_NOW(a_clip_pos, out_valid && clipped, vel_x == 32'h7FFF_FFFF || vel_y == 32'h7FFF_FFFF || vel_z == 32'h7FFF_FFFF)
endmodule

@@ test/velocity_vector_checker.sv @@
`timescale 1ns / 1ps
module velocity_vector_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [31:0] target_x,
	input  logic [31:0] target_y,
	input  logic [31:0] target_z,
	input  logic [31:0] origin_x,
	input  logic [31:0] origin_y,
	input  logic [31:0] origin_z,
	input  logic [31:0] speed,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [31:0] vel_x,
	input  logic [31:0] vel_y,
	input  logic [31:0] vel_z,
	input  logic        degenerate,
	input  logic        clipped,
	output int          errors,
	output int          pending
);
	import vvfs_pkg::FRAC_BITS;

	typedef struct packed {
		logic [2:0][31:0] vel;
		logic             degen;
		logic             clip;
	} velocity_t;

	velocity_t velocity_q[$];

	function automatic velocity_t scaled_unit_vector(input logic [2:0][31:0] tgt,
			input logic [2:0][31:0] org, input logic [31:0] spd);
		logic signed [32:0] d;
		logic [2:0][32:0] dm;
		logic [2:0] dneg;
		logic [31:0] sm;
		logic [127:0] sum, radicand, c, num, q, lim;
		logic [63:0] root;
		logic neg;
		velocity_t r;
		r = '0;
		sum = '0;
		for (int i = 0; i < 3; i++) begin
			d = {tgt[i][31], tgt[i]} - {org[i][31], org[i]};
			dneg[i] = d[32];
			dm[i] = d[32] ? -d : d;
			sum = sum + {95'b0, dm[i]} * {95'b0, dm[i]};
		end
		if (sum == 0) begin
			r.degen = 1'b1;
			return r;
		end
		sm = spd[31] ? -spd : spd;
		radicand = sum << (2 * FRAC_BITS);
		root = '0;
		for (int b = 63; b >= 0; b--) begin
			c = {64'b0, root | (64'd1 << b)};
			if (c * c <= radicand)
				root = c[63:0];
		end
		for (int i = 0; i < 3; i++) begin
			neg = spd[31] ^ dneg[i];
			num = ({96'b0, sm} * {95'b0, dm[i]}) << FRAC_BITS;
			q = num / {64'b0, root};
			lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
			if (q > lim) begin
				q = lim;
				r.clip = 1'b1;
			end
			r.vel[i] = neg ? -q[31:0] : q[31:0];
		end
		return r;
	endfunction

	assign pending = velocity_q.size();

	always @(posedge clk or negedge arst_n) begin
		velocity_t e;
		if (!arst_n) begin
			errors <= 0;
			velocity_q.delete();
		end else begin
			if (in_valid && !in_stall)
				velocity_q.push_back(scaled_unit_vector({target_z, target_y, target_x},
					{origin_z, origin_y, origin_x}, speed));
			if (out_valid && !out_stall) begin
				if (velocity_q.size() == 0) begin
					$error("unexpected result item");
					errors <= errors + 1;
				end else begin
					e = velocity_q.pop_front();
					if (vel_x !== e.vel[0] || vel_y !== e.vel[1] || vel_z !== e.vel[2] ||
							degenerate !== e.degen || clipped !== e.clip)
						errors <= errors + 1;
					if (vel_x !== e.vel[0])
						$error("vel_x expected %h actual %h", e.vel[0], vel_x);
					if (vel_y !== e.vel[1])
						$error("vel_y expected %h actual %h", e.vel[1], vel_y);
					if (vel_z !== e.vel[2])
						$error("vel_z expected %h actual %h", e.vel[2], vel_z);
					if (degenerate !== e.degen)
						$error("degenerate expected %b actual %b", e.degen, degenerate);
					if (clipped !== e.clip)
						$error("clipped expected %b actual %b", e.clip, clipped);
				end
			end
		end
	end
endmodule

@@ test/tb_velocity_vector_from_segment.sv @@
`timescale 1ns / 1ps
module tb_velocity_vector_from_segment;
	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_stall;
	logic [31:0] target_x = 0, target_y = 0, target_z = 0;
	logic [31:0] origin_x = 0, origin_y = 0, origin_z = 0;
	logic [31:0] speed = 0;
	logic out_valid;
	logic out_stall = 0;
	logic [31:0] vel_x, vel_y, vel_z;
	logic degenerate, clipped;
	int errors, pending;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;

	always #2 clk = ~clk;

	velocity_vector_from_segment u_top (.*);
	velocity_vector_checker u_chk (.*);

	always @(posedge clk)
		out_stall <= ($urandom_range(99) < recv_idle_pct);

	task automatic send_segment(input logic [31:0] tx, ty, tz, ox, oy, oz, sp);
		logic ok;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		target_x <= tx; target_y <= ty; target_z <= tz;
		origin_x <= ox; origin_y <= oy; origin_z <= oz;
		speed <= sp;
		in_valid <= 1'b1;
		do begin
			@(negedge clk);
			ok = !in_stall;
			@(posedge clk);
		end while (!ok);
	endtask

	function automatic logic [31:0] pick_coord();
		case ($urandom_range(4))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return $urandom_range(16'hFFFF) - 32'h8000;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [31:0] pick_speed();
		case ($urandom_range(6))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'h0;
			3: return $urandom_range(32'h000F_FFFF) - 32'h0008_0000;
			default: return $urandom;
		endcase
	endfunction

	task automatic random_segment();
		logic [31:0] t[3], o[3];
		int mode;
		mode = $urandom_range(9);
		for (int i = 0; i < 3; i++) begin
			t[i] = pick_coord();
			case (mode)
				0: o[i] = t[i];
				1, 2: o[i] = t[i] + $urandom_range(32'h3FFFF) - 32'h20000;
				3: o[i] = (i == 0) ? pick_coord() : t[i];
				default: o[i] = pick_coord();
			endcase
		end
		send_segment(t[0], t[1], t[2], o[0], o[1], o[2], pick_speed());
	endtask

	initial begin
		#2000000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		int wait_cycles;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_idle_pct = 15;
		recv_idle_pct = 45;
		// directed corner items
		send_segment(0, 0, 0, 0, 0, 0, 32'h0001_0000);
		send_segment(5, 5, 5, 5, 5, 5, 32'h8000_0000);
		send_segment(32'h0001_0000, 0, 0, 0, 0, 0, 32'h8000_0000);
		send_segment(0, 32'h0001_0000, 0, 0, 0, 0, 32'h7FFF_FFFF);
		send_segment(0, 0, 32'h8000_0000, 0, 0, 0, 32'h8000_0000);
		send_segment(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
		send_segment(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
		send_segment(32'h7FFF_FFFF, 0, 0, 32'h8000_0000, 0, 0, 32'h8000_0000);
		send_segment(32'h0003_0000, 32'h0004_0000, 0, 0, 0, 0, 32'h0005_0000);
		send_segment(32'h0003_0000, 32'h0004_0000, 0, 0, 0, 0, 0);
		send_segment(1, 1, 1, 0, 0, 0, 32'h8000_0000);
		send_segment(1, 0, 0, 0, 0, 0, 32'hFFFF_FFFF);
		send_segment(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0, 32'h0001_0000);
		send_segment(0, 0, 0, 32'h7FFF_FFFF, 1, 32'h8000_0000, 32'h7FFF_FFFF);
		send_segment(32'h1234_5678, 32'h9ABC_DEF0, 32'h0F0F_0F0F,
			32'hF0F0_F0F0, 32'h5555_5555, 32'hAAAA_AAAA, 32'hDEAD_BEEF);
		for (int i = 0; i < 700; i++) random_segment();
		send_idle_pct = 45;
		recv_idle_pct = 15;
		for (int i = 0; i < 700; i++) random_segment();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		for (int i = 0; i < 600; i++) random_segment();
		in_valid <= 1'b0;
		wait_cycles = 0;
		while (pending != 0 && wait_cycles < 20000) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (120) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule

@@ filelist.f @@
+incdir+rtl
rtl/vvfs_pkg.sv
rtl/vvfs_sqrt_cell.sv
rtl/vvfs_div_cell.sv
rtl/velocity_vector_from_segment.sv
test/velocity_vector_checker.sv
test/tb_velocity_vector_from_segment.sv
